>>> hdl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic scaler package
// Shared widths, operation codes and register indexes of the bicubic scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int PIXEL_W    = 3 * PIX_W;
    localparam int SIZE_CFG_W = 10;
    localparam int STEP_W     = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = COORD_W + STEP_W;
    localparam int FX_W       = POS_W - FRAC_W;
    localparam int DIST_W     = FRAC_W + 2;
    localparam int POLY_W     = 56;
    localparam int WGT_TAPS   = 8;
    localparam int WGT_LAT    = 3;

    localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(1) << FRAC_W;
    localparam logic [DIST_W-1:0] TWO_Q16 = DIST_W'(2) << FRAC_W;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 2'd3;

endpackage

>>> hdl/bis_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, with registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_din,
    output logic [WIDTH-1:0]         o_dout
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_dout;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_din;
        end
        r_dout <= r_mem[i_addr];
    end

    assign o_dout = r_dout;

endmodule

>>> hdl/bis_wgt.sv
// ----------------------------------------------------------------------------
// Keys weight unit
// Three-stage pipeline that turns a Q2.16 tap distance into a rounded weight.
// ----------------------------------------------------------------------------
module bis_wgt #(
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [bis_pkg::DIST_W-1:0]         i_dist,
    output logic                               o_valid,
    output logic signed [WEIGHT_FRAC_BITS+1:0] o_weight
);

    localparam int DW = bis_pkg::DIST_W;
    localparam int SW = 2 * DW;
    localparam int CW = 3 * DW;
    localparam int PW = bis_pkg::POLY_W;

    logic          r_v1, r_v2, r_v3;
    logic [DW-1:0] r_d1, r_d2;
    logic [SW-1:0] r_sq1, r_sq2;
    logic [CW-1:0] r_cu2;
    logic signed [WEIGHT_FRAC_BITS+1:0] r_w3;

    logic signed [PW-1:0] n_d, n_sq, n_cu, n_poly, n_round;

    always_comb begin
        n_d  = signed'(PW'(r_d2));
        n_sq = signed'(PW'(r_sq2)) <<< bis_pkg::FRAC_W;
        n_cu = signed'(PW'(r_cu2));
        if (r_d2 < bis_pkg::ONE_Q16) begin
            n_poly = 3 * n_cu - 5 * n_sq + (PW'(1) <<< 49);
        end else begin
            n_poly = -n_cu + 5 * n_sq - (n_d <<< 35) + (PW'(1) <<< 50);
        end
        n_round = (n_poly + (PW'(1) <<< (48 - WEIGHT_FRAC_BITS))) >>> (49 - WEIGHT_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_d1  <= i_dist;
        r_sq1 <= SW'(i_dist * i_dist);
        r_d2  <= r_d1;
        r_sq2 <= r_sq1;
        r_cu2 <= CW'(r_sq1 * r_d1);
        if (r_d2 < bis_pkg::TWO_Q16) begin
            r_w3 <= n_round[WEIGHT_FRAC_BITS+1:0];
        end else begin
            r_w3 <= '0;
        end
    end

    assign o_valid  = r_v3;
    assign o_weight = r_w3;

endmodule

>>> hdl/bicubic_image_scale_core.sv
// ----------------------------------------------------------------------------
// Bicubic image scale core
// Stores a three-channel source frame and resamples it with Keys weights.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. A load
// transaction writes one source pixel in that cycle, gives no result and
// leaves busy low, so loads can be issued in every cycle. A compute
// transaction raises busy and yields one result, shown on the output ports
// for one cycle with o_strobe high; the receiver cannot stall it.
// A border copy passes through the map, decode and border states before it
// strobes. An interpolated pixel has its coordinate mapped in the map and
// decode states; the weight pipeline then produces the eight weights, the
// sixteen taps are read one each from the single-port frame memory, and the
// multiply-accumulate stages drain. busy drops with the strobe, so the next
// transaction can be accepted in the strobe cycle. Configuration writes take
// effect at once and must be made while idle; the block does not enforce it.
// Reset clears the control state and restores the register defaults; the
// frame memory is not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
module bicubic_image_scale_core #(
    parameter int MAX_SRC_WIDTH    = 512,
    parameter int MAX_SRC_HEIGHT   = 512,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [bis_pkg::COORD_W-1:0]       i_coord_x,
    input  logic [bis_pkg::COORD_W-1:0]       i_coord_y,
    input  logic [bis_pkg::PIX_W-1:0]         i_in_chan0,
    input  logic [bis_pkg::PIX_W-1:0]         i_in_chan1,
    input  logic [bis_pkg::PIX_W-1:0]         i_in_chan2,
    output logic                              o_strobe,
    output logic [bis_pkg::PIX_W-1:0]         o_out_chan0,
    output logic [bis_pkg::PIX_W-1:0]         o_out_chan1,
    output logic [bis_pkg::PIX_W-1:0]         o_out_chan2,
    output logic                              o_border_copy,
    input  logic                              i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bis_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLW    = $clog2(MAX_SRC_WIDTH);
    localparam int RLW    = $clog2(MAX_SRC_HEIGHT);
    localparam int WW     = WEIGHT_FRAC_BITS + 2;
    localparam int WTW    = 2 * WW;
    localparam int PRW    = WTW + bis_pkg::PIX_W + 1;
    localparam int ACW    = 2 * WEIGHT_FRAC_BITS + 16;
    localparam int FXW    = bis_pkg::FX_W;
    localparam int PXW    = bis_pkg::PIX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_WGT  = 3'd4;
    localparam logic [2:0] S_TAP  = 3'd5;
    localparam logic [2:0] S_DRN  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic [4:0] WGT_END = 5'(bis_pkg::WGT_TAPS + bis_pkg::WGT_LAT - 1);

    logic [2:0]                       r_state;
    logic [4:0]                       r_cnt;
    logic [bis_pkg::SIZE_CFG_W-1:0]   r_src_w, r_src_h;
    logic [bis_pkg::STEP_W-1:0]       r_step_x, r_step_y;
    logic [bis_pkg::COORD_W-1:0]      r_cx, r_cy;
    logic [bis_pkg::POS_W-1:0]        r_px, r_py;
    logic [ADDR_W-1:0]                r_base;
    logic [bis_pkg::FRAC_W-1:0]       r_tx, r_ty;
    logic signed [WW-1:0]             r_wq [bis_pkg::WGT_TAPS];
    logic                             r_av, r_alast, r_bv, r_blast;
    logic signed [WTW-1:0]            r_wt;
    logic signed [PRW-1:0]            r_prod [3];
    logic signed [ACW-1:0]            r_acc [3];
    logic                             r_valid, r_border;
    logic [PXW-1:0]                   r_out [3];

    logic                  accept, load_we;
    logic [FXW-1:0]        w_eff, h_eff, fx, fy, col_full, row_full;
    logic                  border;
    logic [ADDR_W-1:0]     wr_addr, brd_addr, tap_addr, ram_addr;
    logic [bis_pkg::PIXEL_W-1:0] ram_din, ram_dout;
    logic [1:0]            tap_i, tap_j;
    logic [bis_pkg::FRAC_W-1:0]  wt_t;
    logic [bis_pkg::DIST_W-1:0]  wt_dist;
    logic                  wgt_in_valid, wgt_out_valid;
    logic signed [WW-1:0]  wgt_out;
    logic [PXW-1:0]        res [3];
    logic [15:0]           acc_int [3];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign load_we = accept && (i_operation == bis_pkg::OP_LOAD)
                  && ({1'b0, i_coord_x} < (bis_pkg::COORD_W + 1)'(MAX_SRC_WIDTH))
                  && ({1'b0, i_coord_y} < (bis_pkg::COORD_W + 1)'(MAX_SRC_HEIGHT));

    always_comb begin
        if (r_src_w == '0) begin
            w_eff = FXW'(1);
        end else if (FXW'(r_src_w) > FXW'(MAX_SRC_WIDTH)) begin
            w_eff = FXW'(MAX_SRC_WIDTH);
        end else begin
            w_eff = FXW'(r_src_w);
        end
        if (r_src_h == '0) begin
            h_eff = FXW'(1);
        end else if (FXW'(r_src_h) > FXW'(MAX_SRC_HEIGHT)) begin
            h_eff = FXW'(MAX_SRC_HEIGHT);
        end else begin
            h_eff = FXW'(r_src_h);
        end
    end

    assign fx = r_px[bis_pkg::POS_W-1:bis_pkg::FRAC_W];
    assign fy = r_py[bis_pkg::POS_W-1:bis_pkg::FRAC_W];
    assign border = (fx <= FXW'(1)) || ((FXW + 1)'(fx) + (FXW + 1)'(3) >= (FXW + 1)'(w_eff))
                 || (fy <= FXW'(1)) || ((FXW + 1)'(fy) + (FXW + 1)'(3) >= (FXW + 1)'(h_eff));
    assign col_full = (fx >= w_eff) ? (w_eff - FXW'(1)) : fx;
    assign row_full = (fy >= h_eff) ? (h_eff - FXW'(1)) : fy;

    assign wr_addr  = ADDR_W'(i_coord_y[RLW-1:0]) * ADDR_W'(MAX_SRC_WIDTH)
                    + ADDR_W'(i_coord_x[CLW-1:0]);
    assign brd_addr = ADDR_W'(row_full[RLW-1:0]) * ADDR_W'(MAX_SRC_WIDTH)
                    + ADDR_W'(col_full[CLW-1:0]);
    assign tap_i    = r_cnt[3:2];
    assign tap_j    = r_cnt[1:0];
    assign tap_addr = r_base + ADDR_W'(tap_j) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(tap_i);
    assign ram_din  = {i_in_chan2, i_in_chan1, i_in_chan0};

    always_comb begin
        case (r_state)
            S_DEC:   ram_addr = brd_addr;
            S_TAP:   ram_addr = tap_addr;
            default: ram_addr = wr_addr;
        endcase
    end

    bis_ram #(
        .WIDTH (bis_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_addr (ram_addr),
        .i_din  (ram_din),
        .o_dout (ram_dout)
    );

    assign wt_t = r_cnt[2] ? r_ty : r_tx;
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    wt_dist = bis_pkg::ONE_Q16 + bis_pkg::DIST_W'(wt_t);
            2'd1:    wt_dist = bis_pkg::DIST_W'(wt_t);
            2'd2:    wt_dist = bis_pkg::ONE_Q16 - bis_pkg::DIST_W'(wt_t);
            default: wt_dist = bis_pkg::TWO_Q16 - bis_pkg::DIST_W'(wt_t);
        endcase
    end
    assign wgt_in_valid = (r_state == S_WGT) && !r_cnt[4] && !r_cnt[3];

    bis_wgt #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_wgt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (wgt_in_valid),
        .i_dist   (wt_dist),
        .o_valid  (wgt_out_valid),
        .o_weight (wgt_out)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_int[c] = r_acc[c][ACW-1:2*WEIGHT_FRAC_BITS];
            if (r_acc[c] <= 0) begin
                res[c] = '0;
            end else if (acc_int[c] > 16'd255) begin
                res[c] = 8'hFF;
            end else begin
                res[c] = acc_int[c][PXW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_valid  <= 1'b0;
            r_av     <= 1'b0;
            r_bv     <= 1'b0;
            r_src_w  <= bis_pkg::SIZE_CFG_W'(512);
            r_src_h  <= bis_pkg::SIZE_CFG_W'(512);
            r_step_x <= bis_pkg::STEP_W'(65536);
            r_step_y <= bis_pkg::STEP_W'(65536);
        end else begin
            r_valid <= 1'b0;
            r_av    <= 1'b0;
            r_bv    <= r_av;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bis_pkg::REG_SRC_WIDTH:  r_src_w  <= i_cfg_data[bis_pkg::SIZE_CFG_W-1:0];
                    bis_pkg::REG_SRC_HEIGHT: r_src_h  <= i_cfg_data[bis_pkg::SIZE_CFG_W-1:0];
                    bis_pkg::REG_STEP_X:     r_step_x <= i_cfg_data[bis_pkg::STEP_W-1:0];
                    bis_pkg::REG_STEP_Y:     r_step_y <= i_cfg_data[bis_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_operation == bis_pkg::OP_COMPUTE)) begin
                        r_state <= S_MAP;
                    end
                end
                S_MAP: r_state <= S_DEC;
                S_DEC: begin
                    r_cnt   <= '0;
                    r_state <= border ? S_BRD : S_WGT;
                end
                S_BRD: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_WGT: begin
                    if (r_cnt == WGT_END) begin
                        r_cnt   <= '0;
                        r_state <= S_TAP;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_TAP: begin
                    r_av <= 1'b1;
                    if (r_cnt[3:0] == 4'hF) begin
                        r_cnt   <= '0;
                        r_state <= S_DRN;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DRN: begin
                    if (r_bv && r_blast) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (r_state == S_MAP) begin
            r_px <= bis_pkg::POS_W'(r_cx * r_step_x);
            r_py <= bis_pkg::POS_W'(r_cy * r_step_y);
        end
        if (r_state == S_DEC) begin
            r_base <= ADDR_W'(fy[RLW-1:0] - RLW'(1)) * ADDR_W'(MAX_SRC_WIDTH)
                    + ADDR_W'(fx[CLW-1:0] - CLW'(1));
            r_tx   <= r_px[bis_pkg::FRAC_W-1:0];
            r_ty   <= r_py[bis_pkg::FRAC_W-1:0];
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_bv) begin
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= r_acc[c] + ACW'(r_prod[c]);
            end
        end
        if (wgt_out_valid) begin
            for (int k = 0; k < bis_pkg::WGT_TAPS - 1; k++) begin
                r_wq[k] <= r_wq[k+1];
            end
            r_wq[bis_pkg::WGT_TAPS-1] <= wgt_out;
        end else if (r_state == S_TAP) begin
            r_wq[4] <= r_wq[5];
            r_wq[5] <= r_wq[6];
            r_wq[6] <= r_wq[7];
            r_wq[7] <= r_wq[4];
            if (tap_j == 2'd3) begin
                r_wq[0] <= r_wq[1];
                r_wq[1] <= r_wq[2];
                r_wq[2] <= r_wq[3];
                r_wq[3] <= r_wq[0];
            end
        end
        r_wt    <= WTW'(r_wq[0] * r_wq[4]);
        r_alast <= (r_cnt[3:0] == 4'hF);
        r_blast <= r_alast;
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= PRW'(signed'({1'b0, ram_dout[c*PXW +: PXW]}) * r_wt);
        end
        if (r_state == S_BRD) begin
            r_border <= 1'b1;
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= ram_dout[c*PXW +: PXW];
            end
        end else if (r_state == S_FIN) begin
            r_border <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= res[c];
            end
        end
    end

    assign o_strobe      = r_valid;
    assign o_out_chan0   = r_out[0];
    assign o_out_chan1   = r_out[1];
    assign o_out_chan2   = r_out[2];
    assign o_border_copy = r_border;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe lasted more than one cycle");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_we |-> (r_state == S_IDLE))
        else $error("frame write while a compute transaction is active");

    a_tap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP && r_cnt[3:0] != 4'hF) |=> (r_cnt == $past(r_cnt) + 5'd1))
        else $error("tap counter skipped");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == bis_pkg::OP_LOAD) |=> !busy)
        else $error("load transaction raised busy");

endmodule
